// ----- design/lpct_pkg.sv -----
// Shared types and constants for the linear-probe code table.
package lpct_pkg;

    localparam int unsigned SLOT_CNT = 2048;
    localparam int unsigned IDX_W    = $clog2(SLOT_CNT);
    localparam int unsigned CAP_W    = 12;
    localparam int unsigned KEY_W    = 24;
    localparam int unsigned HKEY_W   = 19;
    localparam int unsigned BIT_W    = $clog2(HKEY_W);

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(SLOT_CNT);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOT_CNT - 1);
    localparam logic [BIT_W-1:0] BIT_FIRST = BIT_W'(HKEY_W - 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_REFUSED  = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [15:0] code;
        logic [7:0]  key_class;
        logic [31:0] value_handle;
        logic [7:0]  value_length;
    } lpct_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_handle;
        logic [7:0]  found_length;
    } lpct_rsp_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [31:0]      handle;
        logic [7:0]       length;
    } lpct_slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_RESP
    } lpct_state_t;

endpackage

// ----- design/linear_probe_code_table.sv -----
// Linear-probe code table: top level with sequencer, modulo unit and slot memory.
//
// Open-addressing hash table keyed by {code, key_class}, one request at a time.
// After reset the block runs a clearing pass over all 2048 slots of the slot memory
// and holds busy high meanwhile; cfg writes are taken at any time (cfg_ready is
// always high), but should only change slots_in_use while the table is idle.
// A request is taken on a cycle with start high and busy low. Its result shows
// on rsp for exactly one cycle with done high, and the receiver cannot stall it.
// Per request: an insert refused by the half-full count, or any request with
// zero slots in use, shows done in the next cycle. Otherwise the home slot is
// found by a restoring modulo over a 19-bit dividend (one remainder bit per
// cycle), then each probe is a registered memory read followed by a compare,
// and a result state follows the last probe. A request makes from one probe
// up to the slot count in use.
module linear_probe_code_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lpct_pkg::lpct_req_t  req,
    output logic                 done,
    output lpct_pkg::lpct_rsp_t  rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [11:0]          cfg_data
);

    lpct_pkg::lpct_state_t state_reg, state_next;

    logic [lpct_pkg::IDX_W-1:0]  clr_reg;
    logic [lpct_pkg::CAP_W-1:0]  slots_reg;
    logic [lpct_pkg::CAP_W-1:0]  cnt_reg;
    logic [lpct_pkg::CAP_W-1:0]  cap_reg;
    logic [lpct_pkg::CAP_W-1:0]  probe_reg;
    logic [lpct_pkg::IDX_W-1:0]  idx_reg;
    logic [lpct_pkg::HKEY_W-1:0] hkey_reg;
    logic [lpct_pkg::BIT_W-1:0]  bit_reg;
    lpct_pkg::lpct_req_t         req_reg;
    lpct_pkg::lpct_rsp_t         rsp_reg;
    lpct_pkg::lpct_slot_t        rd_reg;

    // slot memory: used flag, key and payload in one word
    lpct_pkg::lpct_slot_t mem [lpct_pkg::SLOT_CNT];

    logic                        mem_we;
    logic [lpct_pkg::IDX_W-1:0]  mem_addr;
    lpct_pkg::lpct_slot_t        mem_wdata;

    // request-time decisions
    logic [lpct_pkg::CAP_W-1:0]  cap_in;
    logic                        early_out;

    // modulo step
    logic [lpct_pkg::CAP_W-1:0]  rem_sh;
    logic [lpct_pkg::CAP_W-1:0]  rem_sub;
    logic [lpct_pkg::IDX_W-1:0]  rem_new;

    // probe step
    logic [lpct_pkg::CAP_W-1:0]  idx_inc;
    logic [lpct_pkg::IDX_W-1:0]  idx_wrap;
    logic [lpct_pkg::CAP_W-1:0]  probe_inc;
    logic                        hit_empty;
    logic                        hit_key;
    logic                        last_probe;
    logic                        is_insert;

    assign cap_in    = (slots_reg > lpct_pkg::CAP_MAX) ? lpct_pkg::CAP_MAX : slots_reg;
    // zero slots: lookup misses, insert refused; full by count: insert refused
    assign early_out = (cap_in == '0)
                    || ((req.operation == lpct_pkg::OP_INSERT) && (cnt_reg >= (cap_in >> 1)));

    // restoring remainder, one dividend bit per cycle
    assign rem_sh  = {1'b0, idx_reg} << 1 | lpct_pkg::CAP_W'(hkey_reg[lpct_pkg::HKEY_W-1]);
    assign rem_sub = rem_sh - cap_reg;
    assign rem_new = (rem_sh >= cap_reg) ? rem_sub[lpct_pkg::IDX_W-1:0]
                                         : rem_sh[lpct_pkg::IDX_W-1:0];

    assign idx_inc    = {1'b0, idx_reg} + lpct_pkg::CAP_W'(1);
    assign idx_wrap   = (idx_inc == cap_reg) ? '0 : idx_inc[lpct_pkg::IDX_W-1:0];
    assign probe_inc  = probe_reg + lpct_pkg::CAP_W'(1);
    assign last_probe = (probe_inc == cap_reg);
    assign hit_empty  = !rd_reg.used;
    assign hit_key    = (rd_reg.key == {req_reg.code, req_reg.key_class});
    assign is_insert  = (req_reg.operation == lpct_pkg::OP_INSERT);

    assign cfg_ready = 1'b1;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpct_pkg::S_CLEAR:
            begin
                if (clr_reg == lpct_pkg::IDX_LAST)
                    state_next = lpct_pkg::S_IDLE;
            end
            lpct_pkg::S_IDLE:
            begin
                if (start)
                    state_next = early_out ? lpct_pkg::S_RESP : lpct_pkg::S_MOD;
            end
            lpct_pkg::S_MOD:
            begin
                if (bit_reg == '0)
                    state_next = lpct_pkg::S_READ;
            end
            lpct_pkg::S_READ:
                state_next = lpct_pkg::S_CHECK;
            lpct_pkg::S_CHECK:
            begin
                if (hit_empty || hit_key || last_probe)
                    state_next = lpct_pkg::S_RESP;
                else
                    state_next = lpct_pkg::S_READ;
            end
            lpct_pkg::S_RESP:
                state_next = lpct_pkg::S_IDLE;
            default:
                state_next = lpct_pkg::S_IDLE;
        endcase
    end

    // outputs and memory write port
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = idx_reg;
        mem_wdata = '{used: 1'b1, key: {req_reg.code, req_reg.key_class},
                      handle: req_reg.value_handle, length: req_reg.value_length};
        unique case (state_reg)
            lpct_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            lpct_pkg::S_IDLE:
                busy = 1'b0;
            lpct_pkg::S_CHECK:
                mem_we = is_insert && (hit_empty || hit_key);
            lpct_pkg::S_RESP:
                done = 1'b1;
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpct_pkg::S_CLEAR;
            clr_reg   <= '0;
            slots_reg <= lpct_pkg::CAP_MAX;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                slots_reg <= cfg_data;
            if (state_reg == lpct_pkg::S_CLEAR)
                clr_reg <= clr_reg + lpct_pkg::IDX_W'(1);
            if ((state_reg == lpct_pkg::S_CHECK) && is_insert && hit_empty)
                cnt_reg <= cnt_reg + lpct_pkg::CAP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lpct_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_reg   <= req;
                    cap_reg   <= cap_in;
                    hkey_reg  <= {req.code, req.key_class[2:0]};
                    bit_reg   <= lpct_pkg::BIT_FIRST;
                    idx_reg   <= '0;
                    probe_reg <= '0;
                    rsp_reg   <= '{status: (req.operation == lpct_pkg::OP_LOOKUP)
                                           ? lpct_pkg::ST_MISSING : lpct_pkg::ST_REFUSED,
                                   found_handle: '0, found_length: '0};
                end
            end
            lpct_pkg::S_MOD:
            begin
                idx_reg  <= rem_new;
                hkey_reg <= hkey_reg << 1;
                bit_reg  <= bit_reg - lpct_pkg::BIT_W'(1);
            end
            lpct_pkg::S_CHECK:
            begin
                priority if (hit_empty)
                begin
                    rsp_reg <= '{status: is_insert ? lpct_pkg::ST_INSERTED
                                                   : lpct_pkg::ST_MISSING,
                                 found_handle: '0, found_length: '0};
                end
                else if (hit_key)
                begin
                    if (is_insert)
                        rsp_reg <= '{status: lpct_pkg::ST_UPDATED,
                                     found_handle: '0, found_length: '0};
                    else
                        rsp_reg <= '{status: lpct_pkg::ST_FOUND,
                                     found_handle: rd_reg.handle,
                                     found_length: rd_reg.length};
                end
                else if (last_probe)
                begin
                    rsp_reg <= '{status: is_insert ? lpct_pkg::ST_REFUSED
                                                   : lpct_pkg::ST_MISSING,
                                 found_handle: '0, found_length: '0};
                end
                else
                begin
                    idx_reg   <= idx_wrap;
                    probe_reg <= probe_inc;
                end
            end
            default:
            begin
                rsp_reg <= rsp_reg;
            end
        endcase
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[idx_reg];
    end

endmodule

// ----- design/lpct_checker.sv -----
// Port-level checks for the linear-probe code table, bound to the top level.
module lpct_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input lpct_pkg::lpct_rsp_t rsp
);

    // a result is only shown while a request is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // one result cycle per request
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // an accepted request blocks the next one
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accept");

    // payload only on a hit
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != lpct_pkg::ST_FOUND))
            |-> ((rsp.found_handle == '0) && (rsp.found_length == '0)))
        else $error("payload on non-hit");

endmodule

bind linear_probe_code_table lpct_checker u_lpct_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the linear-probe code table: directed corners plus random traffic.
`timescale 1ns / 100ps

module testbench;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    lpct_pkg::lpct_req_t req;
    logic                done;
    lpct_pkg::lpct_rsp_t rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [11:0]         cfg_data;

    linear_probe_code_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 4 ns clock, high then low
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table. Mirrors the block's slot store, entry
    // counter and slot-count register; updated when a request is taken.
    // ------------------------------------------------------------------
    bit          shadow_used   [lpct_pkg::SLOT_CNT];
    bit [23:0]   shadow_key    [lpct_pkg::SLOT_CNT];
    bit [31:0]   shadow_handle [lpct_pkg::SLOT_CNT];
    bit [7:0]    shadow_length [lpct_pkg::SLOT_CNT];
    bit [11:0]   shadow_entries;
    bit [11:0]   shadow_slots;

    lpct_pkg::lpct_rsp_t pending_rsp[$];   // expected results, oldest first
    bit [23:0]   key_pool[$];      // keys sent with inserts, reused for hits
    bit          idle_on;          // random start gaps enabled
    int          request_count;
    int          cfg_writes;
    int          mismatch_count;
    int          outcome_count[8];

    // Apply one request to the shadow table and return the result it
    // should produce. Home slot is {code, class[2:0]} mod the active slot
    // count; the count saturates at SLOT_CNT. Probing is linear and wraps.
    function automatic lpct_pkg::lpct_rsp_t apply_to_table(input lpct_pkg::lpct_req_t r);
        int unsigned         cap;
        int unsigned         pos;
        int unsigned         n;
        bit [23:0]           k;
        lpct_pkg::lpct_rsp_t o;
        cap = (shadow_slots > lpct_pkg::SLOT_CNT) ? lpct_pkg::SLOT_CNT : shadow_slots;
        k   = {r.code, r.key_class};
        o   = '0;
        if (r.operation == lpct_pkg::OP_INSERT)
        begin
            o.status = lpct_pkg::ST_REFUSED;
            // half-full rule: refuse once entries reach floor(cap/2)
            if (cap != 0 && shadow_entries < cap / 2)
            begin
                pos = {r.code, r.key_class[2:0]} % cap;
                for (n = 0; n < cap; n++)
                begin
                    if (!shadow_used[pos])
                    begin
                        shadow_used[pos]   = 1'b1;
                        shadow_key[pos]    = k;
                        shadow_handle[pos] = r.value_handle;
                        shadow_length[pos] = r.value_length;
                        shadow_entries     = shadow_entries + 12'd1;
                        o.status           = lpct_pkg::ST_INSERTED;
                        break;
                    end
                    if (shadow_key[pos] == k)
                    begin
                        shadow_handle[pos] = r.value_handle;
                        shadow_length[pos] = r.value_length;
                        o.status           = lpct_pkg::ST_UPDATED;
                        break;
                    end
                    pos = (pos + 1 == cap) ? 0 : pos + 1;
                end
            end
        end
        else
        begin
            o.status = lpct_pkg::ST_MISSING;
            if (cap != 0)
            begin
                pos = {r.code, r.key_class[2:0]} % cap;
                for (n = 0; n < cap; n++)
                begin
                    // an empty slot ends the chain
                    if (!shadow_used[pos])
                        break;
                    if (shadow_key[pos] == k)
                    begin
                        o.found_handle = shadow_handle[pos];
                        o.found_length = shadow_length[pos];
                        o.status       = lpct_pkg::ST_FOUND;
                        break;
                    end
                    pos = (pos + 1 == cap) ? 0 : pos + 1;
                end
            end
        end
        return o;
    endfunction

    function automatic lpct_pkg::lpct_req_t make_req(input logic op, input logic [15:0] code,
                                                     input logic [7:0] cls,
                                                     input logic [31:0] handle,
                                                     input logic [7:0] len);
        lpct_pkg::lpct_req_t r;
        r.operation    = op;
        r.code         = code;
        r.key_class    = cls;
        r.value_handle = handle;
        r.value_length = len;
        return r;
    endfunction

    // Random request. The largest share reuses a key already sent (hits and updates), some
    // keep code and class[2:0] but change class[7:3] (same home slot, other
    // key, so the probe chain is walked), the rest are fresh keys.
    function automatic lpct_pkg::lpct_req_t random_request();
        lpct_pkg::lpct_req_t r;
        int unsigned         pick;
        bit [23:0]           k;
        r.operation    = 1'($urandom_range(1));
        r.value_handle = $urandom;
        r.value_length = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (key_pool.size() != 0 && pick < 65)
        begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            if (pick >= 45)
                k[7:3] = 5'($urandom_range(31));
        end
        else
            k = 24'($urandom);
        {r.code, r.key_class} = k;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. start is held high until the block takes the request
    // (start high, busy low at the edge); with idling on, start drops for
    // a cycle now and then, so gaps land on every phase of the work.
    // start is left high after acceptance: the next call or the caller
    // decides its value in the same step, so it is assigned only once.
    // ------------------------------------------------------------------
    task automatic send_request(input lpct_pkg::lpct_req_t item);
        bit go;
        forever
        begin
            go = !(idle_on && $urandom_range(99) < 6);
            start <= go;
            req   <= item;
            @(posedge clk);
            if (go && !busy)
                break;
        end
        pending_rsp.push_back(apply_to_table(item));
        if (item.operation == lpct_pkg::OP_INSERT)
            key_pool.push_back({item.code, item.key_class});
        request_count++;
    endtask

    // Every request gives exactly one result, so an empty queue means idle.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Slot-count write; only done with the table idle.
    task automatic write_slot_count(input logic [11:0] value);
        start <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_slots = value;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: the block cannot be stalled, so every done cycle is
    // a result that must match the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_rsp
        lpct_pkg::lpct_rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result with nothing expected: status %0d", rsp.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                outcome_count[rsp.status]++;
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.found_handle !== want.found_handle)
                begin
                    $error("found_handle: expected %08h, got %08h",
                           want.found_handle, rsp.found_handle);
                    mismatch_count++;
                end
                if (rsp.found_length !== want.found_length)
                begin
                    $error("found_length: expected %0d, got %0d",
                           want.found_length, rsp.found_length);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset (default 2048 slots): the store must read as empty.
    task automatic test_empty_table();
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h0000, 8'h00, 32'h0, 8'h0));
    endtask

    // Zero slots: inserts refused, lookups miss.
    task automatic test_zero_slots();
        write_slot_count(12'd0);
        send_request(make_req(lpct_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'hFFFF, 8'hFF, 32'h0, 8'h0));
    endtask

    // One slot: half of one rounds to zero, so inserts are refused too.
    task automatic test_one_slot();
        write_slot_count(12'd1);
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h0000, 8'h00, 32'h1234_5678, 8'h12));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h0000, 8'h00, 32'h0, 8'h0));
    endtask

    // Field extremes with an over-range slot count (saturates to the max).
    task automatic test_field_extremes();
        write_slot_count(12'd4095);
        send_request(make_req(lpct_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h0000, 8'h00, 32'h0000_0000, 8'h00));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'hFFFF, 8'hFF, 32'h0, 8'h0));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h0000, 8'h00, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 32'hA5A5_5A5A, 8'h81));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'hFFFF, 8'hFF, 32'h0, 8'h0));
    endtask

    // Keys sharing a home slot: full class is compared, so 0x05 and 0xFD
    // sit in neighboring slots and 0x0D walks the chain and misses.
    task automatic test_home_collision();
        write_slot_count(12'd2048);
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h1234, 8'h05, 32'h0000_0005, 8'h05));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h1234, 8'hFD, 32'h0000_00FD, 8'hFD));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h1234, 8'hFD, 32'h0, 8'h0));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h1234, 8'h0D, 32'h0, 8'h0));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h1234, 8'hFD, 32'hFEED_0001, 8'h7E));
    endtask

    // Fill slots 1..3 at 16 slots, then shrink to 3 with entries kept:
    // every visited slot is used, so a foreign key probes all and misses,
    // inserts are refused, and a held key is found after wrapping.
    task automatic test_shrunk_table();
        write_slot_count(12'd16);
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h0002, 8'h01, 32'h2222_0001, 8'h21));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h0002, 8'h02, 32'h2222_0002, 8'h22));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h0002, 8'h03, 32'h2222_0003, 8'h23));
        write_slot_count(12'd3);
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h0002, 8'h04, 32'h0, 8'h0));
        send_request(make_req(lpct_pkg::OP_INSERT, 16'h0002, 8'h04, 32'h2222_0004, 8'h24));
        send_request(make_req(lpct_pkg::OP_LOOKUP, 16'h0002, 8'h01, 32'h0, 8'h0));
    endtask

    // Random traffic at one slot count; entries carry over between phases.
    task automatic test_random_traffic(input logic [11:0] slots, input int n_items,
                                       input bit with_gaps);
        write_slot_count(slots);
        idle_on = with_gaps;
        repeat (n_items)
            send_request(random_request());
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        // shadow reset state: store clear, count zero, 2048 slots
        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;
        shadow_entries = '0;
        shadow_slots   = 12'd2048;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // block clears its store after reset; the driver just waits on busy
        test_empty_table();
        test_zero_slots();
        test_one_slot();
        test_field_extremes();
        test_home_collision();
        test_shrunk_table();

        // ascending mostly, so the half-full limit leaves room to insert;
        // zero and tiny counts exercise refusal and full-length misses
        test_random_traffic(12'd40, 80, 1'b1);
        test_random_traffic(12'd0, 40, 1'b1);
        test_random_traffic(12'd128, 90, 1'b1);
        test_random_traffic(12'd3, 40, 1'b1);
        test_random_traffic(12'd512, 100, 1'b1);
        test_random_traffic(12'd2048, 110, 1'b0);
        test_random_traffic(12'd4095, 90, 1'b1);
        test_random_traffic(12'd1999, 100, 1'b1);

        start <= 1'b0;
        wait_drained();
        // catch any stray result after the last one
        repeat (64) @(posedge clk);

        $display("Sent %0d requests across %0d slot-count writes", request_count, cfg_writes);
        $display("(zero, one, small, 2048, over-range). Outcomes seen: %0d inserted,",
                 outcome_count[lpct_pkg::ST_INSERTED]);
        $display("%0d updated, %0d found, %0d missing, %0d refused.",
                 outcome_count[lpct_pkg::ST_UPDATED], outcome_count[lpct_pkg::ST_FOUND],
                 outcome_count[lpct_pkg::ST_MISSING], outcome_count[lpct_pkg::ST_REFUSED]);
        if (mismatch_count == 0)
            $display("PASS linear_probe_code_table");
        else
            $display("FAIL linear_probe_code_table");
        $finish;
    end

    // Watchdog: far beyond every request walking a full 2048-slot chain.
    initial
    begin
        #40_000_000;
        $display("FAIL linear_probe_code_table");
        $finish;
    end

endmodule

// ----- sim.f -----
design/lpct_pkg.sv
design/linear_probe_code_table.sv
design/lpct_checker.sv
tb/sv/testbench.sv
